// File: src/owtf_pkg.sv
`timescale 1ns / 1ps
// Package for the overwrite-oldest trace FIFO: sizes, operation codes,
// record and control structs, and the threshold level table. No dependencies.
package owtf_pkg;

  localparam int DEPTH     = 256;
  localparam int AW        = $clog2(DEPTH);
  localparam int CW        = $clog2(DEPTH + 1);
  localparam int PEND_W    = 9;
  localparam int LOST_W    = 32;
  localparam int THR_W     = 7;
  localparam int THR_N     = 2 ** THR_W;
  localparam int PCT_SCALE = 100;
  localparam int LVL_W     = $clog2((DEPTH * (THR_N - 1)) / PCT_SCALE + 1);
  localparam int CMP_W     = (LVL_W > CW) ? LVL_W : CW;
  localparam int THR_RESET = 90;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_THRESH = 1'b1;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_FLUSH   = 2'd2,
    OP_RESTART = 2'd3
  } op_e;

  typedef struct packed {
    logic [31:0] tick;
    logic [31:0] delta;
    logic [31:0] inst_flow;
    logic [31:0] smooth_flow;
    logic [7:0]  evt;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef struct packed {
    logic             enable;
    logic [LVL_W-1:0] level;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic do_read;
    logic load_rec;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
    logic nonempty;
  } sts_t;

  typedef logic [LVL_W-1:0] lvl_tab_t [THR_N];

  function automatic lvl_tab_t build_lvl_tab();
    lvl_tab_t tab;
    for (int i = 0; i < THR_N; i++) begin
      tab[i] = LVL_W'((DEPTH * i) / PCT_SCALE);
    end
    return tab;
  endfunction

  localparam lvl_tab_t LVL_TAB = build_lvl_tab();

endpackage

// File: src/owtf_ram.sv
`timescale 1ns / 1ps
// Generic RAM: one write port, one read port with registered read data.
// No dependencies.
module owtf_ram #(
  parameter int DATA_W = 8,
  parameter int WORDS  = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(WORDS)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(WORDS)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [WORDS];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/owtf_cfg.sv
`timescale 1ns / 1ps
// APB register block: logging enable and threshold percentage, with the
// threshold level looked up on write. Depends on owtf_pkg.
module owtf_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [owtf_pkg::APB_AW-1:0] paddr,
  input  logic [owtf_pkg::APB_DW-1:0] pwdata,
  output logic [owtf_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output owtf_pkg::cfg_t              cfg_o
);
  import owtf_pkg::*;

  logic             en_q, en_d;
  logic [THR_W-1:0] thr_q, thr_d;
  logic [LVL_W-1:0] lvl_q, lvl_d;
  logic             wr;

  assign wr = psel & penable & pwrite;

  always_comb begin
    en_d  = en_q;
    thr_d = thr_q;
    lvl_d = lvl_q;
    if (wr) begin
      unique case (paddr[2])
        REG_ENABLE: en_d = pwdata[0];
        REG_THRESH: begin
          thr_d = pwdata[THR_W-1:0];
          lvl_d = LVL_TAB[pwdata[THR_W-1:0]];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q  <= 1'b0;
      thr_q <= THR_W'(THR_RESET);
      lvl_q <= LVL_TAB[THR_RESET];
    end else begin
      en_q  <= en_d;
      thr_q <= thr_d;
      lvl_q <= lvl_d;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ENABLE: prdata = APB_DW'(en_q);
      REG_THRESH: prdata = APB_DW'(thr_q);
      default:    prdata = '0;
    endcase
  end

  assign pready       = 1'b1;
  assign cfg_o.enable = en_q;
  assign cfg_o.level  = lvl_q;

endmodule

// File: src/owtf_ctrl.sv
`timescale 1ns / 1ps
// Controller: request handshake and the wait for registered RAM read data
// on a pop. Depends on owtf_pkg.
module owtf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          op_i,
  input  owtf_pkg::sts_t      sts_i,
  output logic                in_ready_o,
  output owtf_pkg::cmd_t      cmd_o
);
  import owtf_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RD   = 1'b1;

  logic state_q, state_d;

  assign in_ready_o     = (state_q == S_IDLE) && !sts_i.out_busy;
  assign cmd_o.accept   = in_valid_i && in_ready_o;
  assign cmd_o.do_read  = cmd_o.accept && (op_e'(op_i) == OP_POP) && sts_i.nonempty;
  assign cmd_o.load_rec = (state_q == S_RD);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (cmd_o.do_read) state_d = S_RD;
      S_RD:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_rd_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |-> !in_ready_o)
    else $error("request taken during read wait");

  a_rd_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |-> $past(cmd_o.do_read))
    else $error("read wait without pop");

endmodule

// File: src/owtf_dp.sv
`timescale 1ns / 1ps
// Datapath: positions, held count, loss counter, record RAM and the result
// register. Depends on owtf_pkg and owtf_ram.
module owtf_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  owtf_pkg::cmd_t              cmd_i,
  input  owtf_pkg::cfg_t              cfg_i,
  input  logic [1:0]                  op_i,
  input  owtf_pkg::rec_t              rec_i,
  input  logic                        out_ready_i,
  output owtf_pkg::sts_t              sts_o,
  output logic                        out_valid_o,
  output logic                        rec_valid_o,
  output owtf_pkg::rec_t              rec_o,
  output logic [owtf_pkg::PEND_W-1:0] pending_o,
  output logic [owtf_pkg::LOST_W-1:0] lost_o,
  output logic                        above_o
);
  import owtf_pkg::*;

  logic [AW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [LOST_W-1:0] loss_q, loss_d;
  logic              ov_q, ov_d;
  logic              recv_q;
  rec_t              rec_q;
  logic [PEND_W-1:0] pend_q;
  logic [LOST_W-1:0] lost_q;
  logic              above_q;
  logic              ram_we;
  rec_t              ram_rdata;
  op_e               op;
  logic              full;

  function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign op     = op_e'(op_i);
  assign full   = (cnt_q == CW'(DEPTH));
  assign ram_we = cmd_i.accept && (op == OP_PUSH) && cfg_i.enable;

  always_comb begin
    wr_d   = wr_q;
    rd_d   = rd_q;
    cnt_d  = cnt_q;
    loss_d = loss_q;
    if (cmd_i.accept) begin
      case (op) inside
        OP_PUSH: begin
          if (cfg_i.enable) begin
            wr_d = next_pos(wr_q);
            if (!full) begin
              cnt_d = cnt_q + 1'b1;
            end else begin
              rd_d = next_pos(rd_q);
              if (loss_q != '1) loss_d = loss_q + 1'b1;
            end
          end
        end
        OP_POP: begin
          if (cnt_q != '0) begin
            rd_d  = next_pos(rd_q);
            cnt_d = cnt_q - 1'b1;
          end
        end
        OP_FLUSH, OP_RESTART: begin
          wr_d  = '0;
          rd_d  = '0;
          cnt_d = '0;
          if (op == OP_RESTART) loss_d = '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    ov_d = ov_q && !out_ready_i;
    if (cmd_i.accept && !cmd_i.do_read) ov_d = 1'b1;
    if (cmd_i.load_rec) ov_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      cnt_q  <= '0;
      loss_q <= '0;
      ov_q   <= 1'b0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      cnt_q  <= cnt_d;
      loss_q <= loss_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      recv_q  <= 1'b0;
      rec_q   <= '0;
      pend_q  <= PEND_W'(cnt_d);
      lost_q  <= loss_d;
      above_q <= (CMP_W'(cnt_d) >= CMP_W'(cfg_i.level));
    end else if (cmd_i.load_rec) begin
      recv_q <= 1'b1;
      rec_q  <= ram_rdata;
    end
  end

  owtf_ram #(
    .DATA_W (REC_W),
    .WORDS  (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_q),
    .wdata_i (rec_i),
    .re_i    (cmd_i.do_read),
    .raddr_i (rd_q),
    .rdata_o (ram_rdata)
  );

  assign sts_o.out_busy = ov_q && !out_ready_i;
  assign sts_o.nonempty = (cnt_q != '0);
  assign out_valid_o    = ov_q;
  assign rec_valid_o    = recv_q;
  assign rec_o          = rec_q;
  assign pending_o      = pend_q;
  assign lost_o         = lost_q;
  assign above_o        = above_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("held count beyond depth");

  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_rec |-> !ov_q)
    else $error("record lands on an untaken result");

  a_full_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && full) |=> (cnt_q == CW'(DEPTH)) && (rd_q == wr_q))
    else $error("overwrite lost track of the positions");

endmodule

// File: src/overwrite_oldest_trace_fifo.sv
`timescale 1ns / 1ps
// Top level of the overwrite-oldest trace FIFO. Depends on owtf_pkg,
// owtf_cfg, owtf_ctrl, owtf_dp and owtf_ram.
//
// Usage: a request carries an operation (push, pop, flush, restart) and, for
// a push, one five-field record. Every request yields exactly one result on
// the output channel: the popped record with its valid flag (zero fields
// otherwise), the pending count, the saturating loss count and the threshold
// flag. Records live in one RAM of DEPTH entries with a registered read port.
// A result is registered in the cycle after its request is taken; a pop of a
// non-empty FIFO registers the RAM read data first. Throughput: one request
// per cycle while results are taken, except a pop that returns a record, which
// holds the request side while the RAM read port delivers the entry.
// A push into a full FIFO overwrites the oldest record and counts a loss.
// The APB port holds logging enable (0x0) and threshold percentage (0x4);
// write them only while no request is in flight.
// Reset empties the FIFO, clears the loss count, disables logging and sets
// the threshold to 90 percent; no clearing pass is needed.
// When the receiver stalls, the result is held and a new request is taken
// only in the cycle the result is taken.
module overwrite_oldest_trace_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [owtf_pkg::APB_AW-1:0]   paddr,
  input  logic [owtf_pkg::APB_DW-1:0]   pwdata,
  output logic [owtf_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    operation_i,
  input  logic [31:0]                   tick_stamp_i,
  input  logic [31:0]                   delta_ms_i,
  input  logic [31:0]                   inst_flow_bits_i,
  input  logic [31:0]                   smoothed_flow_bits_i,
  input  logic [7:0]                    event_code_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          record_valid_o,
  output logic [31:0]                   tick_stamp_out_o,
  output logic [31:0]                   delta_ms_out_o,
  output logic [31:0]                   inst_flow_out_o,
  output logic [31:0]                   smoothed_flow_out_o,
  output logic [7:0]                    event_out_o,
  output logic [owtf_pkg::PEND_W-1:0]   pending_count_o,
  output logic [owtf_pkg::LOST_W-1:0]   lost_count_o,
  output logic                          above_threshold_o
);
  import owtf_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;
  rec_t rec_in;
  rec_t rec_out;

  assign rec_in.tick        = tick_stamp_i;
  assign rec_in.delta       = delta_ms_i;
  assign rec_in.inst_flow   = inst_flow_bits_i;
  assign rec_in.smooth_flow = smoothed_flow_bits_i;
  assign rec_in.evt         = event_code_i;

  owtf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  owtf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (operation_i),
    .sts_i      (sts),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  owtf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_i       (cfg),
    .op_i        (operation_i),
    .rec_i       (rec_in),
    .out_ready_i (out_ready_i),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .rec_valid_o (record_valid_o),
    .rec_o       (rec_out),
    .pending_o   (pending_count_o),
    .lost_o      (lost_count_o),
    .above_o     (above_threshold_o)
  );

  assign tick_stamp_out_o    = rec_out.tick;
  assign delta_ms_out_o      = rec_out.delta;
  assign inst_flow_out_o     = rec_out.inst_flow;
  assign smoothed_flow_out_o = rec_out.smooth_flow;
  assign event_out_o         = rec_out.evt;

endmodule

// File: test/tb_overwrite_oldest_trace_fifo.sv
`timescale 1ns / 1ps
// Self-checking bench for overwrite_oldest_trace_fifo: directed and random
// requests with random idling on both sides, checked by a scoreboard class.
// Depends on owtf_pkg and the RTL under src only.
module tb_overwrite_oldest_trace_fifo;
  import owtf_pkg::*;

  localparam int STALL_AT     = 700;
  localparam int STALL_CYCLES = 300;
  localparam int QUIET_LIMIT  = 2000;

  localparam logic [APB_AW-1:0] ADDR_ENABLE = APB_AW'(REG_ENABLE) << 2;
  localparam logic [APB_AW-1:0] ADDR_THRESH = APB_AW'(REG_THRESH) << 2;

  typedef struct packed {
    logic              valid;
    rec_t              rec;
    logic [PEND_W-1:0] pend;
    logic [LOST_W-1:0] lost;
    logic              above;
  } trace_result_t;

  class trace_fifo_scoreboard;
    rec_t            store [DEPTH];
    int unsigned     wr_pos, rd_pos, held, thr_pct;
    logic [31:0]     lost;
    bit              enabled;
    trace_result_t   due [$];
    int              n_errors, n_checked;

    function new();
      wr_pos = 0; rd_pos = 0; held = 0; lost = '0;
      enabled = 1'b0; thr_pct = THR_RESET;
      n_errors = 0; n_checked = 0;
    endfunction

    function void set_register(logic [APB_AW-1:0] addr, logic [31:0] data);
      if (addr == ADDR_ENABLE) enabled = data[0];
      else if (addr == ADDR_THRESH) thr_pct = data[THR_W-1:0];
    endfunction

    function void note_request(op_e op, rec_t r);
      trace_result_t res;
      res = '0;
      case (op)
        OP_PUSH: if (enabled) begin
          store[wr_pos] = r;
          wr_pos = (wr_pos + 1) % DEPTH;
          if (held < DEPTH) held++;
          else begin
            rd_pos = (rd_pos + 1) % DEPTH;
            if (lost != '1) lost++;
          end
        end
        OP_POP: if (held > 0) begin
          res.valid = 1'b1;
          res.rec   = store[rd_pos];
          rd_pos    = (rd_pos + 1) % DEPTH;
          held--;
        end
        default: begin
          wr_pos = 0; rd_pos = 0; held = 0;
          if (op == OP_RESTART) lost = '0;
        end
      endcase
      res.pend  = PEND_W'(held);
      res.lost  = lost;
      res.above = (held >= (DEPTH * thr_pct) / PCT_SCALE);
      due.push_back(res);
    endfunction

    function void cmp(string name, logic [31:0] e, logic [31:0] g);
      if (g !== e) begin
        $error("%s: expected %h, got %h", name, e, g);
        n_errors++;
      end
    endfunction

    function void check_result(trace_result_t got);
      trace_result_t e;
      if (due.size() == 0) begin
        $error("result with no request outstanding");
        n_errors++;
        return;
      end
      e = due.pop_front();
      n_checked++;
      cmp("record_valid", e.valid, got.valid);
      cmp("tick_stamp_out", e.rec.tick, got.rec.tick);
      cmp("delta_ms_out", e.rec.delta, got.rec.delta);
      cmp("inst_flow_out", e.rec.inst_flow, got.rec.inst_flow);
      cmp("smoothed_flow_out", e.rec.smooth_flow, got.rec.smooth_flow);
      cmp("event_out", e.rec.evt, got.rec.evt);
      cmp("pending_count", e.pend, got.pend);
      cmp("lost_count", e.lost, got.lost);
      cmp("above_threshold", e.above, got.above);
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [1:0]          operation_i = '0;
  logic [31:0]         tick_stamp_i = '0;
  logic [31:0]         delta_ms_i = '0;
  logic [31:0]         inst_flow_bits_i = '0;
  logic [31:0]         smoothed_flow_bits_i = '0;
  logic [7:0]          event_code_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                record_valid_o;
  logic [31:0]         tick_stamp_out_o;
  logic [31:0]         delta_ms_out_o;
  logic [31:0]         inst_flow_out_o;
  logic [31:0]         smoothed_flow_out_o;
  logic [7:0]          event_out_o;
  logic [PEND_W-1:0]   pending_count_o;
  logic [LOST_W-1:0]   lost_count_o;
  logic                above_threshold_o;

  trace_fifo_scoreboard sb = new();
  bit calm = 1'b0;
  int stall_left = 0;
  bit stall_done = 1'b0;
  int quiet = 0;

  overwrite_oldest_trace_fifo u_top (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        sb.check_result({record_valid_o, tick_stamp_out_o, delta_ms_out_o, inst_flow_out_o,
                         smoothed_flow_out_o, event_out_o, pending_count_o, lost_count_o,
                         above_threshold_o});
      if (!stall_done && sb.n_checked >= STALL_AT) begin
        stall_left = STALL_CYCLES;
        stall_done = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= 27);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic rec_t rand_rec();
    rec_t r;
    r.tick        = $urandom;
    r.delta       = $urandom;
    r.inst_flow   = $urandom;
    r.smooth_flow = $urandom;
    r.evt         = 8'($urandom_range(255));
    return r;
  endfunction

  task automatic send_req(input op_e op, input rec_t r);
    if (!calm) begin
      while ($urandom_range(99) < 27) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i           <= 1'b1;
    operation_i          <= op;
    tick_stamp_i         <= r.tick;
    delta_ms_i           <= r.delta;
    inst_flow_bits_i     <= r.inst_flow;
    smoothed_flow_bits_i <= r.smooth_flow;
    event_code_i         <= r.evt;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(op, r);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_register(addr, data);
    @(posedge clk_i);
  endtask

  task automatic run_phase(input bit en, input int unsigned thr, input int n,
                           input int unsigned push_pct, input int unsigned pop_pct,
                           input int unsigned flush_pct);
    op_e         op;
    int unsigned r;
    settle();
    write_reg(ADDR_ENABLE, 32'(en));
    write_reg(ADDR_THRESH, thr);
    repeat (n) begin
      r = $urandom_range(99);
      if (r < push_pct) op = OP_PUSH;
      else if (r < push_pct + pop_pct) op = OP_POP;
      else if (r < push_pct + pop_pct + flush_pct) op = OP_FLUSH;
      else op = OP_RESTART;
      send_req(op, rand_rec());
    end
  endtask

  initial begin
    rec_t ev_rec;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // logging is off out of reset
    send_req(OP_PUSH, '1);
    send_req(OP_POP, rand_rec());
    send_req(OP_FLUSH, rand_rec());
    send_req(OP_RESTART, rand_rec());
    settle();
    write_reg(ADDR_ENABLE, 32'd1);
    write_reg(ADDR_THRESH, 32'd100);
    send_req(OP_PUSH, '1);
    send_req(OP_PUSH, '0);
    ev_rec = rand_rec(); ev_rec.evt = 8'd1;
    send_req(OP_PUSH, ev_rec);
    ev_rec = rand_rec(); ev_rec.evt = 8'd2;
    send_req(OP_PUSH, ev_rec);
    repeat (5) send_req(OP_POP, '1);
    send_req(OP_PUSH, rand_rec());
    send_req(OP_PUSH, rand_rec());
    send_req(OP_FLUSH, '0);
    send_req(OP_POP, rand_rec());
    send_req(OP_PUSH, rand_rec());
    send_req(OP_RESTART, rand_rec());
    send_req(OP_POP, rand_rec());
    // restart keeps logging enabled
    send_req(OP_PUSH, rand_rec());
    send_req(OP_POP, rand_rec());
    settle();
    write_reg(ADDR_THRESH, 32'd0);
    send_req(OP_POP, rand_rec());
    settle();
    write_reg(ADDR_ENABLE, 32'd0);
    send_req(OP_PUSH, rand_rec());
    send_req(OP_POP, rand_rec());

    run_phase(1'b1, 100, 380, 96, 4, 0);
    run_phase(1'b1, 0, 200, 30, 66, 2);
    run_phase(1'b0, 127, 100, 40, 50, 5);
    run_phase(1'b1, $urandom_range(127), 300, 70, 26, 2);
    calm = 1'b1;
    run_phase(1'b1, 50, 270, 50, 46, 2);
    calm = 1'b0;

    settle();
    repeat (10) @(posedge clk_i);
    if (sb.n_errors == 0 && sb.due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
